// ===== rtl/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg: shared constants for the vector normalizer
// Fixed register width and lane count.
// ----------------------------------------------------------------------------
package v3n_pkg;
  localparam int unsigned MinLenWidth = 16;
  localparam int unsigned NumLanes    = 3;
endpackage

// ===== rtl/v3n_isqrt.sv =====
// ----------------------------------------------------------------------------
// v3n_isqrt: pipelined integer square root
// One result bit per stage, one item per cycle while en is high, with a side payload.
// ----------------------------------------------------------------------------
module v3n_isqrt #(
  parameter int unsigned SW = 34,
  parameter int unsigned RW = 17,
  parameter int unsigned PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [SW-1:0] in_s,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [RW-1:0] out_root,
  output logic [PW-1:0] out_pay
);
  localparam int unsigned AW = 2 * RW;

  logic          vld_r  [1:RW];
  logic [AW-1:0] rem_r  [1:RW];
  logic [RW-1:0] root_r [1:RW];
  logic [PW-1:0] pay_r  [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    localparam int unsigned B = RW - 1 - k;
    logic          vld_in;
    logic [AW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [PW-1:0] pay_in;
    logic [AW-1:0] trial;
    logic [RW-1:0] cand;
    logic [AW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    if (k == 0) begin : g_head
      assign vld_in  = in_vld;
      assign rem_in  = AW'(in_s);
      assign root_in = '0;
      assign pay_in  = in_pay;
    end else begin : g_body
      assign vld_in  = vld_r[k];
      assign rem_in  = rem_r[k];
      assign root_in = root_r[k];
      assign pay_in  = pay_r[k];
    end

    always_comb begin
      cand  = root_in | (RW'(1) << B);
      trial = AW'(cand) * AW'(cand);
    end
    always_comb begin
      // keep the candidate bit when its square still fits
      rem_nxt  = rem_in;
      root_nxt = (trial <= rem_in) ? cand : root_in;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_in;
      end
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        pay_r[k+1]  <= pay_in;
      end
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_pay  = pay_r[RW];
endmodule

// ===== rtl/v3n_div_lane.sv =====
// ----------------------------------------------------------------------------
// v3n_div_lane: pipelined restoring divider lane
// Computes (mag << FB) / len, one quotient bit per stage, and restores sign.
// ----------------------------------------------------------------------------
module v3n_div_lane #(
  parameter int unsigned CW = 16,
  parameter int unsigned FB = 14,
  parameter int unsigned LW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] in_mag,
  input  logic          in_neg,
  input  logic [LW-1:0] in_len,
  output logic [FB+1:0] out_q
);
  localparam int unsigned NW = CW + FB;
  localparam int unsigned OW = FB + 2;

  logic [NW-1:0] num_r [1:NW];
  logic [LW:0]   rem_r [1:NW];
  logic [NW-1:0] quo_r [1:NW];
  logic [LW-1:0] den_r [1:NW];
  logic          neg_r [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stg
    logic [NW-1:0] num_in;
    logic [LW:0]   rem_in;
    logic [NW-1:0] quo_in;
    logic [LW-1:0] den_in;
    logic          neg_in;
    logic [LW+1:0] sh;
    logic [LW+1:0] dif;

    if (k == 0) begin : g_head
      assign num_in = {in_mag, FB'(0)};
      assign rem_in = '0;
      assign quo_in = '0;
      assign den_in = in_len;
      assign neg_in = in_neg;
    end else begin : g_body
      assign num_in = num_r[k];
      assign rem_in = rem_r[k];
      assign quo_in = quo_r[k];
      assign den_in = den_r[k];
      assign neg_in = neg_r[k];
    end

    always_comb begin
      sh  = {rem_in, num_in[NW-1]};
      dif = sh - (LW+2)'(den_in);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k+1] <= num_in << 1;
        rem_r[k+1] <= dif[LW+1] ? sh[LW:0] : dif[LW:0];
        quo_r[k+1] <= {quo_in[NW-2:0], ~dif[LW+1]};
        den_r[k+1] <= den_in;
        neg_r[k+1] <= neg_in;
      end
    end
  end

  logic [OW-1:0] q;
  assign q     = quo_r[NW][OW-1:0];
  assign out_q = neg_r[NW] ? (~q + OW'(1)) : q;
endmodule

// ===== rtl/vector3_normalizer_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_normalizer_unit: 3D vector normalization to signed Q2.FRACTION_BITS
// Streams one vector per cycle while the output is not stalled through a square-root
// pipeline and three parallel divider lanes; a final stage merges the lanes and the range check.
// ----------------------------------------------------------------------------
// Each item is a signed vector (vec_x, vec_y, vec_z). The block forms the
// exact sum of squares, its integer square root L, and, when L is at least
// min_length (and nonzero), each component times 2^FRACTION_BITS divided by
// L, truncated toward zero. Otherwise too_short is set and all components are
// zero. The whole datapath is one pipeline that advances whenever the output
// register is empty or being taken, and a new item is accepted in every such cycle.
// The stages are the magnitude and square registers, the bit-per-stage root
// pipeline, the bit-per-stage divider lanes and the output register.
// min_length is sampled when an item leaves the root stage; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module vector3_normalizer_unit #(
  parameter int unsigned COMPONENT_WIDTH = 16,
  parameter int unsigned FRACTION_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [FRACTION_BITS+1:0]   out_unit_x,
  output logic signed [FRACTION_BITS+1:0]   out_unit_y,
  output logic signed [FRACTION_BITS+1:0]   out_unit_z,
  output logic                              out_too_short,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [v3n_pkg::MinLenWidth-1:0]   cfg_min_length
);
  import v3n_pkg::*;

  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned OW = FB + 2;
  localparam int unsigned SQW = 2 * CW;
  localparam int unsigned SW = SQW + 2;   // sum of three squares
  localparam int unsigned RW = CW + 1;    // root width
  localparam int unsigned PW = NumLanes * (CW + 1);
  localparam int unsigned ND = CW + FB;   // divider depth

  logic en;
  logic [MinLenWidth-1:0] min_len_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MinLenWidth'(1);
    end else if (cfg_valid) begin
      min_len_r <= cfg_min_length;
    end
  end

  // Pipeline advances unless a result waits in the output register unclaimed.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: magnitudes and signs.
  logic [CW-1:0] mag_r [NumLanes];
  logic          neg_r [NumLanes];
  logic          s1_vld_r;
  logic [CW-1:0] vin [NumLanes];
  assign vin[0] = in_vec_x;
  assign vin[1] = in_vec_y;
  assign vin[2] = in_vec_z;

  for (genvar i = 0; i < NumLanes; i++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i] <= vin[i][CW-1];
        mag_r[i] <= vin[i][CW-1] ? (~vin[i] + CW'(1)) : vin[i];
      end
    end
  end

  // Stage 2: squares, one multiplier per lane.
  logic [SQW-1:0] sq_r [NumLanes];
  logic [PW-1:0]  s2_pay_r;
  logic           s2_vld_r;
  for (genvar i = 0; i < NumLanes; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[i] <= SQW'(mag_r[i]) * SQW'(mag_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_pay_r <= {neg_r[2], mag_r[2], neg_r[1], mag_r[1], neg_r[0], mag_r[0]};
    end
  end

  logic [SW-1:0] sum;
  assign sum = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  logic          rt_vld;
  logic [RW-1:0] rt_len;
  logic [PW-1:0] rt_pay;

  v3n_isqrt #(.SW(SW), .RW(RW), .PW(PW)) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s2_vld_r),
    .in_s    (sum),
    .in_pay  (s2_pay_r),
    .out_vld (rt_vld),
    .out_root(rt_len),
    .out_pay (rt_pay)
  );

  // Range check; a rejected item divides by 1 and is zeroed at the merge.
  logic          short;
  logic [RW-1:0] den;
  assign short = (rt_len == '0) || (rt_len < RW'(min_len_r));
  assign den   = short ? RW'(1) : rt_len;

  logic [OW-1:0] q [NumLanes];
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    v3n_div_lane #(.CW(CW), .FB(FB), .LW(RW)) u_lane (
      .clk   (clk),
      .en    (en),
      .in_mag(rt_pay[i*(CW+1) +: CW]),
      .in_neg(rt_pay[i*(CW+1) + CW]),
      .in_len(den),
      .out_q (q[i])
    );
  end

  // Delay line for valid and the error flag alongside the lanes.
  logic [ND-1:0] dv_r;
  logic [ND-1:0] ds_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[ND-2:0], rt_vld};
    end
    if (en) begin
      ds_r <= {ds_r[ND-2:0], short};
    end
  end

  // Merge stage: output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_r[ND-1];
    end
    if (en) begin
      out_too_short <= ds_r[ND-1];
      out_unit_x    <= ds_r[ND-1] ? '0 : q[0];
      out_unit_y    <= ds_r[ND-1] ? '0 : q[1];
      out_unit_z    <= ds_r[ND-1] ? '0 : q[2];
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unit_x))
    else $error("result dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_short |-> out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0)
    else $error("rejected item carries nonzero components");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
`endif
endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking regression for vector3_normalizer_unit
// Drives random and directed vectors through the valid/ready stream, predicts
// each normalized result and checks it field by field, across several
// min_length settings written while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import v3n_pkg::*;

  localparam int unsigned CompW   = 16;
  localparam int unsigned FracW   = 14;
  localparam int unsigned OutW    = FracW + 2;
  // input, root and divider stage counts, without the output register
  localparam int unsigned Latency = 2 + (CompW + 1) + (CompW + FracW);
  localparam int unsigned Drain   = 4 * Latency;

  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } vector_t;

  typedef struct packed {
    logic signed [OutW-1:0] ux;
    logic signed [OutW-1:0] uy;
    logic signed [OutW-1:0] uz;
    logic                   short_flag;
  } unit_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [CompW-1:0] in_vec_x, in_vec_y, in_vec_z;
  logic out_valid;
  logic out_ready;
  logic signed [OutW-1:0] out_unit_x, out_unit_y, out_unit_z;
  logic out_too_short;
  logic cfg_valid;
  logic cfg_ready;
  logic [MinLenWidth-1:0] cfg_min_length;

  vector3_normalizer_unit #(
    .COMPONENT_WIDTH(CompW),
    .FRACTION_BITS  (FracW)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_unit_x    (out_unit_x),
    .out_unit_y    (out_unit_y),
    .out_unit_z    (out_unit_z),
    .out_too_short (out_too_short),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_min_length(cfg_min_length)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  vector_t         pending_vectors[$];
  unit_t           expected_units[$];
  logic [MinLenWidth-1:0] min_length_shadow;
  int              error_count;
  bit              idle_enable;      // random gaps on both sides
  bit              hold_off_request; // long receiver stall
  bit              hold_off_active;

  // floor(sqrt(s)), bit by bit
  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s    = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic unit_t normalize(input vector_t v, input logic [MinLenWidth-1:0] min_len);
    logic signed [CompW-1:0] comp[3];
    logic [63:0] mag[3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    logic [OutW-1:0] res[3];
    unit_t u;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i] < 0 ? 64'(-64'(comp[i])) : 64'(comp[i]);
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    if (len == 0 || len < 64'(min_len)) begin
      u = '{ux: '0, uy: '0, uz: '0, short_flag: 1'b1};
      return u;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << FracW) / len;
      if (comp[i] < 0) q = ~q + 64'd1;
      res[i] = q[OutW-1:0];
    end
    u = '{ux: res[0], uy: res[1], uz: res[2], short_flag: 1'b0};
    return u;
  endfunction

  function automatic logic signed [CompW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return CompW'($signed($urandom_range(0, 6)) - 3);
      2:       return CompW'($signed($urandom_range(0, 400)) - 200);
      default: return CompW'($urandom);
    endcase
  endfunction

  // Driver: hold valid and payload until accepted, advance from the queue.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_units.push_back(normalize('{x: in_vec_x, y: in_vec_y, z: in_vec_z},
                                           min_length_shadow));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (pending_vectors.size() > 0) begin
          vector_t v;
          v = pending_vectors.pop_front();
          in_valid <= 1'b1;
          in_vec_x <= v.x;
          in_vec_y <= v.y;
          in_vec_z <= v.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter: keep the receiver stalled for a fixed stretch.
  int hold_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_count      <= 0;
      hold_off_active <= 1'b0;
    end else if (hold_off_request && !hold_off_active) begin
      hold_off_active <= 1'b1;
      hold_count      <= 3 * Latency;
    end else if (hold_off_active) begin
      if (hold_count > 1) begin
        hold_count <= hold_count - 1;
      end else begin
        hold_off_active <= 1'b0;
        hold_count      <= 0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  int recv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          $error("result with no expectation waiting");
          error_count++;
        end else begin
          unit_t e;
          e = expected_units.pop_front();
          if (out_unit_x !== e.ux) begin
            $error("unit_x expected %0d actual %0d", e.ux, out_unit_x);
            error_count++;
          end
          if (out_unit_y !== e.uy) begin
            $error("unit_y expected %0d actual %0d", e.uy, out_unit_y);
            error_count++;
          end
          if (out_unit_z !== e.uz) begin
            $error("unit_z expected %0d actual %0d", e.uz, out_unit_z);
            error_count++;
          end
          if (out_too_short !== e.short_flag) begin
            $error("too_short expected %0b actual %0b", e.short_flag, out_too_short);
            error_count++;
          end
        end
      end
      if (hold_off_active) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        recv_gap  <= $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    // look after the edge has settled so a just-launched item is seen
    while (pending_vectors.size() > 0 || in_valid || expected_units.size() > 0) begin
      @(posedge clk);
      #1;
    end
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_min_length(input logic [MinLenWidth-1:0] value);
    cfg_min_length <= value;
    cfg_valid      <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_length_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      pending_vectors.push_back('{x: rand_comp(), y: rand_comp(), z: rand_comp()});
  endtask

  logic [MinLenWidth-1:0] settings[5] = '{16'd1, 16'd0, 16'd100, 16'd23170, 16'd65535};

  initial begin
    error_count       = 0;
    idle_enable       = 1'b1;
    hold_off_request  = 1'b0;
    min_length_shadow = 16'd1;  // reset value
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_vec_x       = '0;
    in_vec_y       = '0;
    in_vec_z       = '0;
    cfg_valid      = 1'b0;
    cfg_min_length = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, extremes, axis vectors, tiny lengths.
    pending_vectors.push_back('{x: 0, y: 0, z: 0});
    pending_vectors.push_back('{x: 16'sh7FFF, y: 16'sh7FFF, z: 16'sh7FFF});
    pending_vectors.push_back('{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000});
    pending_vectors.push_back('{x: 16'sh8000, y: 0, z: 0});
    pending_vectors.push_back('{x: 0, y: 16'sh7FFF, z: 0});
    pending_vectors.push_back('{x: 0, y: 0, z: -1});
    pending_vectors.push_back('{x: 1, y: 0, z: 0});
    pending_vectors.push_back('{x: 1, y: 1, z: 1});
    pending_vectors.push_back('{x: -1, y: -1, z: 1});
    pending_vectors.push_back('{x: 3, y: -4, z: 0});
    pending_vectors.push_back('{x: 16'sh5555, y: 16'shAAAA, z: 16'sh00FF});
    pending_vectors.push_back('{x: 16'sh7FFF, y: 16'sh8000, z: 16'sh7FFF});
    wait_idle();

    // Walk the register through its settings, extremes included.
    foreach (settings[k]) begin
      write_min_length(settings[k]);
      pending_vectors.push_back('{x: 0, y: 0, z: 0});
      pending_vectors.push_back('{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000});
      queue_random(80);
      if (k == 2) begin
        // stall the receiver long enough to back up the pipeline
        hold_off_request = 1'b1;
        wait (hold_off_active);
        hold_off_request = 1'b0;
      end
      wait_idle();
    end

    // Final stretch without idling.
    write_min_length(16'd1);
    idle_enable = 1'b0;
    queue_random(150);
    wait_idle();

    repeat (Latency) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * (200000 + 20 * Drain));
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
